// ===== hw/rtl/rv32i_instruction_step_defines.svh =====
// ---------------------------------------------------------------------------
// rv32i instruction step: assertion macros
// shared property templates for the controller checks
// ---------------------------------------------------------------------------
`ifndef RV32I_INSTRUCTION_STEP_DEFINES_SVH
`define RV32I_INSTRUCTION_STEP_DEFINES_SVH

// same-cycle implication
`define RV32S_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RV32S_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rv32s_pkg.sv =====
// ---------------------------------------------------------------------------
// rv32s_pkg
// shared constants, types and functions of the rv32i instruction step block
// ---------------------------------------------------------------------------
package rv32s_pkg;

    localparam int DEF_MEM_ADDR_BITS = 16;

    // commands
    localparam logic [2:0] CMD_STEP  = 3'd0;
    localparam logic [2:0] CMD_SETPC = 3'd1;
    localparam logic [2:0] CMD_WRREG = 3'd2;
    localparam logic [2:0] CMD_RDREG = 3'd3;
    localparam logic [2:0] CMD_WRMEM = 3'd4;
    localparam logic [2:0] CMD_RDMEM = 3'd5;

    // opcodes
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;

    // alu codes: alternate bit on top of funct3
    localparam logic [3:0] ALU_ADD  = 4'h0;
    localparam logic [3:0] ALU_SUB  = 4'h8;
    localparam logic [3:0] ALU_SLL  = 4'h1;
    localparam logic [3:0] ALU_SLT  = 4'h2;
    localparam logic [3:0] ALU_LTU  = 4'h3;
    localparam logic [3:0] ALU_XOR  = 4'h4;
    localparam logic [3:0] ALU_SRL  = 4'h5;
    localparam logic [3:0] ALU_SRA  = 4'hD;
    localparam logic [3:0] ALU_OR   = 4'h6;
    localparam logic [3:0] ALU_AND  = 4'h7;

    // funct3 values that matter for the immediate shift forms
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_SRL = 3'd5;

    // branch conditions
    localparam logic [2:0] BR_EQ  = 3'd0;
    localparam logic [2:0] BR_NE  = 3'd1;
    localparam logic [2:0] BR_LT  = 3'd4;
    localparam logic [2:0] BR_GE  = 3'd5;
    localparam logic [2:0] BR_LTU = 3'd6;
    localparam logic [2:0] BR_GEU = 3'd7;

    // access widths
    localparam logic [2:0] W_BYTE  = 3'd0;
    localparam logic [2:0] W_HALF  = 3'd1;
    localparam logic [2:0] W_WORD  = 3'd2;
    localparam logic [2:0] W_BYTEU = 3'd4;
    localparam logic [2:0] W_HALFU = 3'd5;

    typedef struct packed {
        logic clear;
        logic accept;
        logic exec;
        logic mem_op;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_done;
        logic mem_item;
        logic out_free;
    } t_ctrl_sts;

    function automatic logic [31:0] alu_op(input logic [31:0] a, input logic [31:0] b,
                                           input logic [3:0] code);
        logic [4:0] sh;
        logic [31:0] res;
        sh = b[4:0];
        unique case (code)
            ALU_ADD:  res = a + b;
            ALU_SUB:  res = a - b;
            ALU_SLL:  res = a << sh;
            ALU_SLT:  res = {31'd0, $signed(a) < $signed(b)};
            ALU_LTU:  res = {31'd0, a < b};
            ALU_XOR:  res = a ^ b;
            ALU_SRL:  res = a >> sh;
            ALU_SRA:  res = $unsigned($signed(a) >>> sh);
            ALU_OR:   res = a | b;
            ALU_AND:  res = a & b;
            default:  res = 32'd0;
        endcase
        return res;
    endfunction

    function automatic logic branch_taken(input logic [31:0] a, input logic [31:0] b,
                                          input logic [2:0] f3);
        logic t;
        unique case (f3)
            BR_EQ:   t = (a == b);
            BR_NE:   t = (a != b);
            BR_LT:   t = ($signed(a) < $signed(b));
            BR_GE:   t = !($signed(a) < $signed(b));
            BR_LTU:  t = (a < b);
            BR_GEU:  t = (a >= b);
            default: t = 1'b0;
        endcase
        return t;
    endfunction

    // bytes written by a store: only the two half widths move two bytes
    function automatic logic [2:0] width_bytes(input logic [2:0] w);
        logic [2:0] n;
        if (w == W_WORD) begin
            n = 3'd4;
        end else if (w == W_HALF || w == W_HALFU) begin
            n = 3'd2;
        end else begin
            n = 3'd1;
        end
        return n;
    endfunction

    function automatic logic [31:0] load_format(input logic [31:0] raw, input logic [2:0] w);
        logic [31:0] v;
        if (w == W_BYTE) begin
            v = {{24{raw[7]}}, raw[7:0]};
        end else if (w == W_BYTEU) begin
            v = {24'd0, raw[7:0]};
        end else if (w == W_WORD) begin
            v = raw;
        end else if (w == W_HALF) begin
            v = {{16{raw[15]}}, raw[15:0]};
        end else begin
            v = {16'd0, raw[15:0]};
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/rv32s_if.sv =====
// ---------------------------------------------------------------------------
// rv32s channel interfaces
// valid/ready channels for command items and result items
// ---------------------------------------------------------------------------
interface rv32s_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [31:0] instruction;
    logic [4:0]  reg_index;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [2:0]  access_width;

    modport source (output valid, command, instruction, reg_index, address, write_data,
                    access_width, input ready);
    modport sink (input valid, command, instruction, reg_index, address, write_data,
                  access_width, output ready);
endinterface

interface rv32s_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pc_after;
    logic [31:0] read_data;
    logic        reg_written;
    logic [4:0]  written_index;
    logic [31:0] written_value;

    modport source (output valid, pc_after, read_data, reg_written, written_index,
                    written_value, input ready);
    modport sink (input valid, pc_after, read_data, reg_written, written_index,
                  written_value, output ready);
endinterface

// ===== hw/rtl/rv32s_ctrl.sv =====
// ---------------------------------------------------------------------------
// rv32s_ctrl
// sequencer: memory clearing, accept, execute, memory access, writeback
// ---------------------------------------------------------------------------
`include "rv32i_instruction_step_defines.svh"

module rv32s_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rv32s_pkg::t_ctrl_sts i_sts,
    output rv32s_pkg::t_ctrl_cmd o_cmd
);
    import rv32s_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_MEM   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clear_done) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_EXEC;
            S_EXEC:  n_state = i_sts.mem_item ? S_MEM : S_DONE;
            S_MEM:   n_state = S_DONE;
            S_DONE:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.clear   = (r_state == S_CLEAR);
    assign o_cmd.accept  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.mem_op  = (r_state == S_MEM);
    assign o_cmd.finish  = (r_state == S_DONE) && i_sts.out_free;

    `RV32S_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, r_state == S_IDLE && i_in_valid, r_state == S_EXEC, "accepted transaction did not move to execute")
    `RV32S_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n, r_state == S_DONE && !i_sts.out_free, r_state == S_DONE, "result dropped while output register busy")
    `RV32S_ASSERT_HOLDS(a_mem_only_mem_item, i_clk, i_rst_n, r_state == S_MEM, i_sts.mem_item, "memory access for a non-memory transaction")
    `RV32S_ASSERT_NEXT(a_clear_runs, i_clk, i_rst_n, r_state == S_CLEAR && !i_sts.clear_done, r_state == S_CLEAR, "clearing pass left early")

endmodule

// ===== hw/rtl/rv32s_dpath.sv =====
// ---------------------------------------------------------------------------
// rv32s_dpath
// register file, decode and alu, four byte banks of data memory, result register
// ---------------------------------------------------------------------------
module rv32s_dpath #(
    parameter int MEM_ADDR_BITS = rv32s_pkg::DEF_MEM_ADDR_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rv32s_pkg::t_ctrl_cmd i_cmd,
    output rv32s_pkg::t_ctrl_sts o_sts,
    input  logic [2:0]           i_command,
    input  logic [31:0]          i_instruction,
    input  logic [4:0]           i_reg_index,
    input  logic [31:0]          i_address,
    input  logic [31:0]          i_write_data,
    input  logic [2:0]           i_access_width,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [31:0]          o_pc_after,
    output logic [31:0]          o_read_data,
    output logic                 o_reg_written,
    output logic [4:0]           o_written_index,
    output logic [31:0]          o_written_value
);
    import rv32s_pkg::*;

    localparam int ROW_BITS = MEM_ADDR_BITS - 2;
    localparam int ROWS     = 2 ** ROW_BITS;

    // latched transaction
    logic [2:0]  r_cmd;
    logic [31:0] r_ins;
    logic [4:0]  r_ridx;
    logic [31:0] r_addr;
    logic [31:0] r_wdat;
    logic [2:0]  r_aw;
    logic [31:0] r_pc;

    // register file
    logic [31:0] rf [32];
    logic [31:0] r_rf_vld;
    logic [31:0] r_a_raw;
    logic [31:0] r_b_raw;
    logic        r_a_ok;
    logic        r_b_ok;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] a;
    logic [31:0] b;
    logic        rf_we;
    logic [4:0]  rf_widx;
    logic [31:0] rf_wdat;

    assign rs1 = (i_command == CMD_STEP) ? i_instruction[19:15] : i_reg_index;
    assign rs2 = i_instruction[24:20];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd   <= i_command;
            r_ins   <= i_instruction;
            r_ridx  <= i_reg_index;
            r_addr  <= i_address;
            r_wdat  <= i_write_data;
            r_aw    <= i_access_width;
            r_a_raw <= rf[rs1];
            r_b_raw <= rf[rs2];
            r_a_ok  <= r_rf_vld[rs1] && (rs1 != 5'd0);
            r_b_ok  <= r_rf_vld[rs2] && (rs2 != 5'd0);
        end
        if (rf_we) begin
            rf[rf_widx] <= rf_wdat;
        end
    end

    assign a = r_a_ok ? r_a_raw : 32'd0;
    assign b = r_b_ok ? r_b_raw : 32'd0;

    // decode and execute
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic [31:0] agen;
    logic [3:0]  imm_code;
    logic [31:0] e_res;
    logic        e_wr;
    logic [31:0] e_npc;

    assign opc   = r_ins[6:0];
    assign rd    = r_ins[11:7];
    assign f3    = r_ins[14:12];
    assign imm_i = {{20{r_ins[31]}}, r_ins[31:20]};
    assign imm_s = {{20{r_ins[31]}}, r_ins[31:25], r_ins[11:7]};
    assign imm_b = {{19{r_ins[31]}}, r_ins[31], r_ins[7], r_ins[30:25], r_ins[11:8], 1'b0};
    assign imm_u = {r_ins[31:12], 12'd0};
    assign imm_j = {{11{r_ins[31]}}, r_ins[31], r_ins[19:12], r_ins[20], r_ins[30:21], 1'b0};
    assign agen  = a + ((opc == OPC_STORE) ? imm_s : imm_i);
    assign imm_code = (f3 == F3_SLL || f3 == F3_SRL) ? {r_ins[30], f3} : {1'b0, f3};

    always_comb begin
        e_res = 32'd0;
        e_wr  = 1'b0;
        e_npc = r_pc + 32'd4;
        unique case (opc)
            OPC_OP:     begin e_res = alu_op(a, b, {r_ins[30], f3}); e_wr = 1'b1; end
            OPC_OPIMM:  begin e_res = alu_op(a, imm_i, imm_code); e_wr = 1'b1; end
            OPC_LUI:    begin e_res = imm_u; e_wr = 1'b1; end
            OPC_AUIPC:  begin e_res = r_pc + imm_u; e_wr = 1'b1; end
            OPC_LOAD:   e_wr = 1'b1;
            OPC_BRANCH: if (branch_taken(a, b, f3)) e_npc = r_pc + imm_b;
            OPC_JAL:    begin e_res = r_pc + 32'd4; e_wr = 1'b1; e_npc = r_pc + imm_j; end
            OPC_JALR:   begin e_res = r_pc + 32'd4; e_wr = 1'b1; e_npc = agen & ~32'd1; end
            default:    e_wr = 1'b0;
        endcase
    end

    logic        is_step;
    assign is_step = (r_cmd == CMD_STEP);

    logic [31:0] r_res;
    logic        r_wr;
    logic [31:0] r_npc;
    logic [31:0] r_eaddr;
    logic [2:0]  r_width;
    logic [31:0] r_sdata;
    logic        r_load;
    logic        r_store;

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res   <= e_res;
            r_wr    <= is_step && e_wr && (rd != 5'd0);
            if (is_step) begin
                r_npc <= e_npc;
            end else if (r_cmd == CMD_SETPC) begin
                r_npc <= r_addr;
            end else begin
                r_npc <= r_pc;
            end
            r_eaddr <= is_step ? agen : r_addr;
            r_width <= is_step ? f3 : r_aw;
            r_sdata <= is_step ? b : r_wdat;
            r_load  <= (is_step && opc == OPC_LOAD) || (r_cmd == CMD_RDMEM);
            r_store <= (is_step && opc == OPC_STORE) || (r_cmd == CMD_WRMEM);
        end
    end

    assign o_sts.mem_item = (is_step && (opc == OPC_LOAD || opc == OPC_STORE))
                            || (r_cmd == CMD_WRMEM) || (r_cmd == CMD_RDMEM);

    // data memory: bank k holds the bytes whose address is k modulo four
    logic [ROW_BITS-1:0] r_clr_row;
    logic [1:0]          lane;
    logic [ROW_BITS-1:0] row_base;
    logic [2:0]          nbytes;
    logic [7:0]          r_bq [4];

    assign lane     = r_eaddr[1:0];
    assign row_base = r_eaddr[ROW_BITS+1:2];
    assign nbytes   = width_bytes(r_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
        end else if (i_cmd.clear) begin
            r_clr_row <= r_clr_row + 1'b1;
        end
    end

    assign o_sts.clear_done = (r_clr_row == {ROW_BITS{1'b1}});

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [7:0]          mem [ROWS];
        logic [1:0]          off;
        logic [ROW_BITS-1:0] row;
        logic                we;
        logic [ROW_BITS-1:0] waddr;
        logic [7:0]          wdata;

        assign off   = 2'(k) - lane;
        assign row   = row_base + ((2'(k) < lane) ? 1'b1 : 1'b0);
        assign we    = i_cmd.clear || (i_cmd.mem_op && r_store && ({1'b0, off} < nbytes));
        assign waddr = i_cmd.clear ? r_clr_row : row;
        assign wdata = i_cmd.clear ? 8'd0 : r_sdata[8*off +: 8];

        always_ff @(posedge i_clk) begin
            if (we) begin
                mem[waddr] <= wdata;
            end
            if (i_cmd.mem_op) begin
                r_bq[k] <= mem[row];
            end
        end
    end

    logic [31:0] ld_raw;
    logic [31:0] ld_val;
    assign ld_raw = {r_bq[2'(lane + 2'd3)], r_bq[2'(lane + 2'd2)],
                     r_bq[2'(lane + 2'd1)], r_bq[lane]};
    assign ld_val = load_format(ld_raw, r_width);

    // writeback
    logic [31:0] wval;
    assign wval    = r_load ? ld_val : r_res;
    assign rf_we   = i_cmd.finish && (is_step ? r_wr : (r_cmd == CMD_WRREG && r_ridx != 5'd0));
    assign rf_widx = is_step ? rd : r_ridx;
    assign rf_wdat = is_step ? wval : r_wdat;

    logic r_ovalid;
    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid    = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= 32'd0;
            r_rf_vld <= 32'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_pc     <= r_npc;
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (rf_we) begin
                r_rf_vld[rf_widx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_pc_after      <= r_npc;
            o_read_data     <= (r_cmd == CMD_RDREG) ? a : ((r_cmd == CMD_RDMEM) ? ld_val : 32'd0);
            o_reg_written   <= is_step && r_wr;
            o_written_index <= (is_step && r_wr) ? rd : 5'd0;
            o_written_value <= (is_step && r_wr) ? wval : 32'd0;
        end
    end

endmodule

// ===== hw/rtl/rv32i_instruction_step.sv =====
// ---------------------------------------------------------------------------
// rv32i_instruction_step
// one rv32i base instruction or debug command per transaction
// ---------------------------------------------------------------------------
// After reset the block clears its data memory one row of four bytes a cycle,
// 2^(MEM_ADDR_BITS-2) rows (16384 at the default size), before taking any
// transaction. Each transaction then passes through accept with register
// file read, execute and writeback, its result being registered into the
// output register at writeback; one that touches data memory (loads, stores,
// memory read and write commands) also has the synchronous read of the byte
// banks between execute and writeback. One transaction is handled at a time
// since each instruction depends on the state left by the last. A finished
// result waits in an output register while the next transaction is accepted;
// its writeback waits until that register is free.
module rv32i_instruction_step #(
    parameter int MEM_ADDR_BITS = rv32s_pkg::DEF_MEM_ADDR_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rv32s_in_if.sink     i_item,
    rv32s_out_if.source  o_result
);
    import rv32s_pkg::*;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    rv32s_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rv32s_dpath #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_command       (i_item.command),
        .i_instruction   (i_item.instruction),
        .i_reg_index     (i_item.reg_index),
        .i_address       (i_item.address),
        .i_write_data    (i_item.write_data),
        .i_access_width  (i_item.access_width),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (o_result.valid),
        .o_pc_after      (o_result.pc_after),
        .o_read_data     (o_result.read_data),
        .o_reg_written   (o_result.reg_written),
        .o_written_index (o_result.written_index),
        .o_written_value (o_result.written_value)
    );

endmodule

// ===== test/rv32i_instruction_step_tb.sv =====
// ---------------------------------------------------------------------------
// rv32i instruction step testbench
// drives directed and random rv32i steps and debug commands through the
// command channel and checks every result against an in-bench rv32i predictor
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module rv32i_instruction_step_tb;
    import rv32s_pkg::*;

    localparam int MEM_BITS = DEF_MEM_ADDR_BITS;
    localparam int MEM_BYTES = 1 << MEM_BITS;
    localparam int N_RANDOM = 1900;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] instruction;
        logic [4:0]  reg_index;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [2:0]  access_width;
    } t_cmd_item;

    typedef struct packed {
        logic [31:0] pc_after;
        logic [31:0] read_data;
        logic        reg_written;
        logic [4:0]  written_index;
        logic [31:0] written_value;
    } t_step_res;

    // directed row: item plus an optional hand-typed result
    typedef struct {
        t_cmd_item item;
        bit        typed;
        t_step_res res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    longint cycle_count;
    int err_count;
    bit done;

    rv32s_in_if  cmd_ch ();
    rv32s_out_if res_ch ();

    rv32i_instruction_step u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (cmd_ch.sink),
        .o_result (res_ch.source)
    );

    // predictor state
    logic [31:0] gpr [32];
    logic [31:0] cur_pc;
    logic [7:0]  dmem [MEM_BYTES];
    t_step_res   pending_res[$];
    t_step_res   typed_res[$];
    bit          typed_flag[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] sx(input logic [31:0] v, input int bits);
        logic [31:0] m;
        m = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1);
        return ((v & m) ^ (32'd1 << (bits - 1))) - (32'd1 << (bits - 1));
    endfunction

    function automatic logic [31:0] gpr_rd(input logic [4:0] i);
        return (i == 5'd0) ? 32'd0 : gpr[i];
    endfunction

    function automatic logic [31:0] mem_fetch(input logic [31:0] a, input logic [2:0] w);
        logic [31:0] v;
        v = {24'd0, dmem[a[MEM_BITS-1:0]]};
        if (w != W_BYTE && w != W_BYTEU) v[15:8] = dmem[(a + 1) & (MEM_BYTES - 1)];
        if (w == W_WORD) begin
            v[23:16] = dmem[(a + 2) & (MEM_BYTES - 1)];
            v[31:24] = dmem[(a + 3) & (MEM_BYTES - 1)];
        end
        if (w == W_BYTE) return sx(v, 8);
        if (w == W_HALF) return sx(v, 16);
        return v;
    endfunction

    task automatic mem_put(input logic [31:0] a, input logic [31:0] v, input logic [2:0] w);
        dmem[a & (MEM_BYTES - 1)] = v[7:0];
        if (w == W_HALF || w == W_HALFU || w == W_WORD) dmem[(a + 1) & (MEM_BYTES - 1)] = v[15:8];
        if (w == W_WORD) begin
            dmem[(a + 2) & (MEM_BYTES - 1)] = v[23:16];
            dmem[(a + 3) & (MEM_BYTES - 1)] = v[31:24];
        end
    endtask

    function automatic logic [31:0] alu_calc(input logic [31:0] a, input logic [31:0] b,
                                             input logic [3:0] code);
        logic [4:0] sh;
        sh = b[4:0];
        case (code)
            ALU_ADD:  return a + b;
            ALU_SUB:  return a - b;
            ALU_SLL:  return a << sh;
            ALU_SLT:  return {31'd0, (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000)};
            ALU_LTU:  return {31'd0, a < b};
            ALU_XOR:  return a ^ b;
            ALU_SRL:  return a >> sh;
            ALU_SRA:  return a[31] ? ~((~a) >> sh) : (a >> sh);
            ALU_OR:   return a | b;
            ALU_AND:  return a & b;
            default:  return 32'd0;
        endcase
    endfunction

    function automatic bit cond_met(input logic [31:0] a, input logic [31:0] b,
                                    input logic [2:0] f3);
        case (f3)
            BR_EQ:   return a == b;
            BR_NE:   return a != b;
            BR_LT:   return (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000);
            BR_GE:   return !((a ^ 32'h8000_0000) < (b ^ 32'h8000_0000));
            BR_LTU:  return a < b;
            BR_GEU:  return a >= b;
            default: return 1'b0;
        endcase
    endfunction

    task automatic run_item(input t_cmd_item it, output t_step_res r);
        logic [31:0] ins, a, b, npc, val, imm_i, imm_s, imm_b, imm_j;
        logic [6:0] opc;
        logic [4:0] rd;
        logic [2:0] f3;
        logic [3:0] alt;
        bit wr;
        r = '0;
        ins = it.instruction;
        case (it.command)
            CMD_STEP: begin
                opc = ins[6:0];
                rd = ins[11:7];
                f3 = ins[14:12];
                a = gpr_rd(ins[19:15]);
                b = gpr_rd(ins[24:20]);
                alt = {ins[30], 3'b000};
                imm_i = sx({20'd0, ins[31:20]}, 12);
                imm_s = sx({20'd0, ins[31:25], ins[11:7]}, 12);
                imm_b = sx({19'd0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
                imm_j = sx({11'd0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
                npc = cur_pc + 4;
                wr = 1'b0;
                val = 32'd0;
                case (opc)
                    OPC_OP: begin
                        val = alu_calc(a, b, alt | {1'b0, f3});
                        wr = 1'b1;
                    end
                    OPC_OPIMM: begin
                        val = alu_calc(a, imm_i, (f3 == F3_SLL || f3 == F3_SRL) ?
                                       (alt | {1'b0, f3}) : {1'b0, f3});
                        wr = 1'b1;
                    end
                    OPC_LUI: begin
                        val = {ins[31:12], 12'd0};
                        wr = 1'b1;
                    end
                    OPC_AUIPC: begin
                        val = cur_pc + {ins[31:12], 12'd0};
                        wr = 1'b1;
                    end
                    OPC_LOAD: begin
                        val = mem_fetch(a + imm_i, f3);
                        wr = 1'b1;
                    end
                    OPC_STORE: mem_put(a + imm_s, b, f3);
                    OPC_BRANCH: if (cond_met(a, b, f3)) npc = cur_pc + imm_b;
                    OPC_JAL: begin
                        val = cur_pc + 4;
                        wr = 1'b1;
                        npc = cur_pc + imm_j;
                    end
                    OPC_JALR: begin
                        val = cur_pc + 4;
                        wr = 1'b1;
                        npc = (a + imm_i) & ~32'd1;
                    end
                    default: ;
                endcase
                if (wr && rd != 5'd0) begin
                    gpr[rd] = val;
                    r.reg_written = 1'b1;
                    r.written_index = rd;
                    r.written_value = val;
                end
                cur_pc = npc;
            end
            CMD_SETPC: cur_pc = it.address;
            CMD_WRREG: if (it.reg_index != 5'd0) gpr[it.reg_index] = it.write_data;
            CMD_RDREG: r.read_data = gpr_rd(it.reg_index);
            CMD_WRMEM: mem_put(it.address, it.write_data, it.access_width);
            CMD_RDMEM: r.read_data = mem_fetch(it.address, it.access_width);
            default: ;
        endcase
        r.pc_after = cur_pc;
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // drive one transaction; prediction happens at acceptance
    task automatic send_item(input t_cmd_item it, input bit typed, input t_step_res tr);
        t_step_res r;
        int g;
        g = gap_len();
        if (g > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        {cmd_ch.command, cmd_ch.instruction, cmd_ch.reg_index, cmd_ch.address,
         cmd_ch.write_data, cmd_ch.access_width} <= it;
        do @(posedge i_clk); while (!cmd_ch.ready);
        run_item(it, r);
        pending_res.push_back(r);
        typed_flag.push_back(typed);
        typed_res.push_back(tr);
        @(negedge i_clk);
    endtask

    // result side: random stalls, compare at the rising edge
    initial begin
        t_step_res want, got, hand;
        bit ht;
        res_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= ($urandom_range(0, 99) < 8) ? 1'b0 : (gap_len() == 0 || $urandom_range(0, 1));
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                got = {res_ch.pc_after, res_ch.read_data, res_ch.reg_written,
                       res_ch.written_index, res_ch.written_value};
                if (pending_res.size() == 0) begin
                    $error("result transaction with nothing expected");
                    err_count++;
                end else begin
                    want = pending_res.pop_front();
                    ht = typed_flag.pop_front();
                    hand = typed_res.pop_front();
                    if (ht && hand != want) begin
                        $error("predictor disagrees with typed row: exp %h pred %h", hand, want);
                        err_count++;
                    end
                    if (got.pc_after != want.pc_after) begin
                        $error("pc_after exp %h act %h", want.pc_after, got.pc_after);
                        err_count++;
                    end
                    if (got.read_data != want.read_data) begin
                        $error("read_data exp %h act %h", want.read_data, got.read_data);
                        err_count++;
                    end
                    if (got.reg_written != want.reg_written) begin
                        $error("reg_written exp %b act %b", want.reg_written, got.reg_written);
                        err_count++;
                    end
                    if (got.written_index != want.written_index) begin
                        $error("written_index exp %0d act %0d", want.written_index,
                               got.written_index);
                        err_count++;
                    end
                    if (got.written_value != want.written_value) begin
                        $error("written_value exp %h act %h", want.written_value,
                               got.written_value);
                        err_count++;
                    end
                end
            end
        end
    end

    function automatic t_cmd_item mk(input logic [2:0] c, input logic [31:0] ins,
                                     input logic [4:0] ri, input logic [31:0] ad,
                                     input logic [31:0] wd, input logic [2:0] aw);
        return {c, ins, ri, ad, wd, aw};
    endfunction

    function automatic t_step_res rs(input logic [31:0] pc, input logic [31:0] rdat,
                                     input logic w, input logic [4:0] wi,
                                     input logic [31:0] wv);
        return {pc, rdat, w, wi, wv};
    endfunction

    function automatic logic [31:0] i_form(input logic [6:0] opc, input logic [4:0] rd,
                                           input logic [2:0] f3, input logic [4:0] rs1,
                                           input logic [11:0] imm);
        return {imm, rs1, f3, rd, opc};
    endfunction

    // random instruction, mostly well formed with small register set
    function automatic logic [31:0] rand_instr();
        logic [31:0] ins;
        logic [6:0] opcs [9];
        int p;
        opcs = '{OPC_OP, OPC_OPIMM, OPC_LUI, OPC_AUIPC, OPC_LOAD, OPC_STORE,
                 OPC_BRANCH, OPC_JAL, OPC_JALR};
        ins = $urandom();
        p = $urandom_range(0, 99);
        if (p < 90) ins[6:0] = opcs[$urandom_range(0, 8)];
        if (p < 60) begin
            ins[19:15] = $urandom_range(0, 7);
            ins[24:20] = $urandom_range(0, 7);
            ins[11:7] = $urandom_range(0, 7);
            if (ins[6:0] == OPC_OP && $urandom_range(0, 3) != 0) ins[31:25] = {1'b0, ins[30], 5'd0};
        end
        return ins;
    endfunction

    function automatic t_cmd_item rand_item();
        t_cmd_item it;
        int p;
        it = $bits(t_cmd_item)'({$urandom(), $urandom(), $urandom(), $urandom()});
        p = $urandom_range(0, 99);
        if (p < 60) it.command = CMD_STEP;
        else if (p < 64) it.command = CMD_SETPC;
        else if (p < 74) it.command = CMD_WRREG;
        else if (p < 82) it.command = CMD_RDREG;
        else if (p < 89) it.command = CMD_WRMEM;
        else if (p < 97) it.command = CMD_RDMEM;
        else it.command = $urandom_range(6, 7);
        it.instruction = rand_instr();
        if ($urandom_range(0, 1)) it.reg_index = $urandom_range(0, 7);
        if ($urandom_range(0, 3) != 0) it.address[31:6] = $urandom_range(0, 1) ? '0 : '1;
        return it;
    endfunction

    initial begin
        t_row rows[$];
        t_step_res none;
        none = '0;
        i_rst_n = 1'b0;
        cycle_count = 0;
        err_count = 0;
        done = 1'b0;
        cmd_ch.valid = 1'b0;
        {cmd_ch.command, cmd_ch.instruction, cmd_ch.reg_index, cmd_ch.address,
         cmd_ch.write_data, cmd_ch.access_width} = '0;
        foreach (gpr[i]) gpr[i] = 32'd0;
        foreach (dmem[i]) dmem[i] = 8'd0;
        cur_pc = 32'd0;

        rows = '{
            '{mk(CMD_RDREG, 0, 5'd31, 0, 0, 0), 1, rs(0, 0, 0, 0, 0)},
            '{mk(CMD_RDMEM, 0, 0, 32'hFFFF_FFFC, 0, W_WORD), 1, rs(0, 0, 0, 0, 0)},
            '{mk(CMD_WRREG, 0, 5'd0, 0, 32'hFFFF_FFFF, 0), 1, rs(0, 0, 0, 0, 0)},
            '{mk(CMD_RDREG, 0, 5'd0, 0, 0, 0), 1, rs(0, 0, 0, 0, 0)},
            '{mk(CMD_WRREG, 0, 5'd1, 0, 32'h8000_0000, 0), 0, none},
            '{mk(CMD_WRREG, 0, 5'd2, 0, 32'hFFFF_FFFF, 0), 0, none},
            '{mk(CMD_WRMEM, 0, 0, 32'hFFFF_FFFE, 32'h8081_8283, W_WORD), 0, none},
            '{mk(CMD_RDMEM, 0, 0, 32'h0000_FFFE, 0, W_BYTE), 1, rs(0, 32'hFFFF_FF83, 0, 0, 0)},
            '{mk(CMD_RDMEM, 0, 0, 32'h0000_FFFE, 0, W_HALFU), 1, rs(0, 32'h0000_8283, 0, 0, 0)},
            '{mk(CMD_RDMEM, 0, 0, 32'h0000_FFFE, 0, 3'd7), 0, none},
            '{mk(CMD_WRMEM, 0, 0, 32'h0000_0010, 32'hA5A5_5A5A, 3'd7), 0, none},
            '{mk(CMD_RDMEM, 0, 0, 32'h0000_0010, 0, W_WORD), 0, none},
            '{mk(CMD_STEP, {7'h20, 5'd2, 5'd1, 3'd0, 5'd3, OPC_OP}, 0, 0, 0, 0), 0, none},
            '{mk(CMD_STEP, {7'h20, 5'd2, 5'd1, 3'd5, 5'd4, OPC_OP}, 0, 0, 0, 0), 0, none},
            '{mk(CMD_STEP, {7'h20, 5'd2, 5'd1, 3'd1, 5'd5, OPC_OP}, 0, 0, 0, 0), 0, none},
            '{mk(CMD_STEP, {7'h20, 5'd5, 5'd1, 3'd1, 5'd6, OPC_OPIMM}, 0, 0, 0, 0), 0, none},
            '{mk(CMD_STEP, i_form(OPC_OPIMM, 5'd7, 3'd2, 5'd1, 12'h7FF), 0, 0, 0, 0), 0, none},
            '{mk(CMD_STEP, i_form(OPC_LOAD, 5'd8, 3'd1, 5'd0, 12'hFFE), 0, 0, 0, 0), 0, none},
            '{mk(CMD_STEP, {7'h7F, 5'd2, 5'd0, 3'd2, 5'h1F, OPC_STORE}, 0, 0, 0, 0), 0, none},
            '{mk(CMD_STEP, {7'h00, 5'd2, 5'd1, 3'd2, 5'd8, OPC_BRANCH}, 0, 0, 0, 0), 0, none},
            '{mk(CMD_STEP, {7'h40, 5'd2, 5'd1, 3'd4, 5'd1, OPC_BRANCH}, 0, 0, 0, 0), 0, none},
            '{mk(CMD_STEP, {20'hFFFFF, 5'd9, OPC_LUI}, 0, 0, 0, 0), 0, none},
            '{mk(CMD_STEP, {20'h80000, 5'd10, OPC_AUIPC}, 0, 0, 0, 0), 0, none},
            '{mk(CMD_STEP, {20'h80000, 5'd11, OPC_JAL}, 0, 0, 0, 0), 0, none},
            '{mk(CMD_STEP, i_form(OPC_JALR, 5'd0, 3'd0, 5'd2, 12'h001), 0, 0, 0, 0), 0, none},
            '{mk(CMD_STEP, 32'hFFFF_FFFF, 0, 0, 0, 0), 0, none},
            '{mk(3'd6, 0, 0, 0, 0, 0), 0, none},
            '{mk(CMD_SETPC, 0, 0, 32'hFFFF_FFFC, 0, 0), 1, rs(32'hFFFF_FFFC, 0, 0, 0, 0)}
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[k]) send_item(rows[k].item, rows[k].typed, rows[k].res);
        repeat (N_RANDOM) send_item(rand_item(), 1'b0, none);
        cmd_ch.valid <= 1'b0;

        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
